// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL; only mtoc_dp.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, trig, cons, msg)
`endif
`endif

// ===== sv/mtoc_pkg.sv =====
// Shared constants and controller/datapath interface types of the tag counter.
package mtoc_pkg;

   localparam int TABLE_ENTRIES_DEF = 32;
   localparam int NAME_BYTES_DEF    = 19;
   localparam int COUNT_BITS_DEF    = 16;

   localparam int NAME_OUT_BITS = 152;
   localparam int LENGTH_BITS   = 5;
   localparam int OCC_BITS      = 16;

   localparam logic [7:0] CHAR_LT    = 8'h3C;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_GT    = 8'h3E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   typedef struct packed {
      logic byte_en;
      logic idx_clr;
      logic idx_inc;
      logic idx_load_top;
      logic idx_dec;
      logic rd_en;
      logic hit_write;
      logic insert;
      logic cap_entry;
      logic cap_empty;
      logic clear_all;
   } dp_cmd_type;

   typedef struct packed {
      logic name_end;
      logic match;
      logic idx_at_end;
      logic idx_zero;
      logic table_empty;
   } dp_status_type;

endpackage

// ===== sv/mtoc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mtoc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mtoc_ctrl.sv =====
// Controller state machine: byte intake, table search sequencing and dump.
module mtoc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    end_of_stream,
   input  mtoc_pkg::dp_status_type status,
   output mtoc_pkg::dp_cmd_type    cmd,
   output logic                    busy
);

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_SRCH_RD  = 6'b000010,
      ST_SRCH_CMP = 6'b000100,
      ST_DUMP_RD  = 6'b001000,
      ST_DUMP_CAP = 6'b010000,
      ST_CLEAR    = 6'b100000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (end_of_stream) begin
                  if (status.table_empty) begin
                     cmd.cap_empty = 1'b1;
                     state_in      = ST_CLEAR;
                  end else begin
                     cmd.idx_load_top = 1'b1;
                     state_in         = ST_DUMP_RD;
                  end
               end else begin
                  cmd.byte_en = 1'b1;
                  if (status.name_end) begin
                     cmd.idx_clr = 1'b1;
                     state_in    = ST_SRCH_RD;
                  end
               end
            end
         end
         ST_SRCH_RD: begin
            if (status.idx_at_end) begin
               cmd.insert = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = ST_SRCH_CMP;
            end
         end
         ST_SRCH_CMP: begin
            if (status.match) begin
               cmd.hit_write = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = ST_SRCH_RD;
            end
         end
         ST_DUMP_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DUMP_CAP;
         end
         ST_DUMP_CAP: begin
            cmd.cap_entry = 1'b1;
            if (status.idx_zero) begin
               state_in = ST_CLEAR;
            end else begin
               cmd.idx_dec = 1'b1;
               state_in    = ST_DUMP_RD;
            end
         end
         ST_CLEAR: begin
            cmd.clear_all = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== sv/mtoc_dp.sv =====
// Datapath: tag parser, name buffer, name table RAM, counters and result registers.
`include "assert_macros.svh"
module mtoc_dp #(
   parameter int TABLE_ENTRIES = mtoc_pkg::TABLE_ENTRIES_DEF,
   parameter int NAME_BYTES    = mtoc_pkg::NAME_BYTES_DEF,
   parameter int COUNT_BITS    = mtoc_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mtoc_pkg::dp_cmd_type    cmd,
   output mtoc_pkg::dp_status_type status,
   input  logic [7:0]              data_byte,
   output logic                    rsp_strobe,
   output logic                    rsp_entry_valid,
   output logic [63:0]             rsp_name_part0,
   output logic [63:0]             rsp_name_part1,
   output logic [23:0]             rsp_name_part2,
   output logic [4:0]              rsp_name_length,
   output logic [15:0]             rsp_occurrences,
   output logic                    rsp_name_truncated,
   output logic                    rsp_table_overflow,
   output logic                    rsp_last
);

   localparam int NAME_W = NAME_BYTES * 8;
   localparam int FILL_W = $clog2(NAME_BYTES + 1);
   localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int ROW_W  = NAME_W + FILL_W + COUNT_BITS;
   localparam int OUT_W  = mtoc_pkg::NAME_OUT_BITS;
   localparam int LEN_W  = mtoc_pkg::LENGTH_BITS;
   localparam int OCC_W  = mtoc_pkg::OCC_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [IDX_W-1:0]      USED_MAX  = IDX_W'(TABLE_ENTRIES);
   localparam logic [FILL_W-1:0]     FILL_MAX  = FILL_W'(NAME_BYTES);

   typedef enum logic [3:0] {
      PM_IDLE     = 4'b0001,
      PM_AFTER_LT = 4'b0010,
      PM_CLOSE    = 4'b0100,
      PM_OPEN     = 4'b1000
   } parse_mode_type;

   parse_mode_type mode_ff, mode_in;
   logic [NAME_W-1:0]     buf_ff, buf_in, buf_base;
   logic [FILL_W-1:0]     fill_ff, fill_in, fill_base;
   logic [IDX_W-1:0]      used_ff, used_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  trunc_ff, trunc_in;
   logic                  ovf_ff, ovf_in;
   logic                  take;
   logic                  name_end;
   logic                  has_room;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [ROW_W-1:0]      ram_wr_data;
   logic [ROW_W-1:0]      ram_rd_data;
   logic [NAME_W-1:0]     rd_name;
   logic [FILL_W-1:0]     rd_len;
   logic [COUNT_BITS-1:0] rd_count;
   logic [COUNT_BITS-1:0] count_next;

   logic                  out_strobe_ff;
   logic                  out_valid_ff;
   logic [NAME_W-1:0]     out_name_ff;
   logic [FILL_W-1:0]     out_len_ff;
   logic [COUNT_BITS-1:0] out_count_ff;
   logic                  out_trunc_ff;
   logic                  out_ovf_ff;
   logic                  out_last_ff;
   logic [OUT_W-1:0]      out_name_wide;

   // Tag parser
   assign name_end = ((mode_ff == PM_CLOSE) && (data_byte == mtoc_pkg::CHAR_GT)) ||
                     ((mode_ff == PM_OPEN) &&
                      ((data_byte == mtoc_pkg::CHAR_GT) || (data_byte == mtoc_pkg::CHAR_SPACE)));

   always_comb begin
      mode_in   = mode_ff;
      buf_base  = buf_ff;
      fill_base = fill_ff;
      take      = 1'b0;
      if (cmd.byte_en) begin
         unique case (mode_ff)
            PM_IDLE: begin
               if (data_byte == mtoc_pkg::CHAR_LT) begin
                  mode_in = PM_AFTER_LT;
               end
            end
            PM_AFTER_LT: begin
               buf_base  = '0;
               fill_base = '0;
               if (data_byte == mtoc_pkg::CHAR_SLASH) begin
                  mode_in = PM_CLOSE;
               end else begin
                  take    = 1'b1;
                  mode_in = PM_OPEN;
               end
            end
            PM_CLOSE, PM_OPEN: begin
               if (name_end) begin
                  mode_in = PM_IDLE;
               end else begin
                  take = 1'b1;
               end
            end
            default: begin
               mode_in = PM_IDLE;
            end
         endcase
      end

      buf_in   = buf_base;
      fill_in  = fill_base;
      trunc_in = trunc_ff;
      if (take) begin
         if (fill_base < FILL_MAX) begin
            for (int j = 0; j < NAME_BYTES; j++) begin
               if (fill_base == FILL_W'(j)) begin
                  buf_in[j*8 +: 8] = data_byte;
               end
            end
            fill_in = FILL_W'(fill_base + 1'b1);
         end else begin
            trunc_in = 1'b1;
         end
      end

      used_in = used_ff;
      ovf_in  = ovf_ff;
      if (cmd.insert) begin
         if (has_room) begin
            used_in = IDX_W'(used_ff + 1'b1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = IDX_W'(idx_ff + 1'b1);
      end else if (cmd.idx_load_top) begin
         idx_in = IDX_W'(used_ff - 1'b1);
      end else if (cmd.idx_dec) begin
         idx_in = IDX_W'(idx_ff - 1'b1);
      end

      if (cmd.clear_all) begin
         mode_in  = PM_IDLE;
         buf_in   = '0;
         fill_in  = '0;
         used_in  = '0;
         trunc_in = 1'b0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= PM_IDLE;
         buf_ff   <= '0;
         fill_ff  <= '0;
         used_ff  <= '0;
         idx_ff   <= '0;
         trunc_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         buf_ff   <= buf_in;
         fill_ff  <= fill_in;
         used_ff  <= used_in;
         idx_ff   <= idx_in;
         trunc_ff <= trunc_in;
         ovf_ff   <= ovf_in;
      end
   end

   // Name table: {name, length, count} per row
   assign has_room   = (used_ff < USED_MAX);
   assign rd_name    = ram_rd_data[ROW_W-1 -: NAME_W];
   assign rd_len     = ram_rd_data[COUNT_BITS +: FILL_W];
   assign rd_count   = ram_rd_data[COUNT_BITS-1:0];
   assign count_next = (rd_count == COUNT_MAX) ? rd_count : COUNT_BITS'(rd_count + 1'b1);

   assign ram_wr_en   = cmd.hit_write | (cmd.insert & has_room);
   assign ram_wr_addr = cmd.hit_write ? idx_ff[ADDR_W-1:0] : used_ff[ADDR_W-1:0];
   assign ram_wr_data = {buf_ff, fill_ff,
                         cmd.hit_write ? count_next : COUNT_BITS'(1)};

   mtoc_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign status.name_end    = name_end;
   assign status.match       = (rd_len == fill_ff) && (rd_name == buf_ff);
   assign status.idx_at_end  = (idx_ff == used_ff);
   assign status.idx_zero    = (idx_ff == '0);
   assign status.table_empty = (used_ff == '0);

   // Result beat registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_strobe_ff <= 1'b0;
      end else begin
         out_strobe_ff <= cmd.cap_entry | cmd.cap_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_entry) begin
         out_valid_ff <= 1'b1;
         out_name_ff  <= rd_name;
         out_len_ff   <= rd_len;
         out_count_ff <= rd_count;
         out_last_ff  <= (idx_ff == '0);
      end else if (cmd.cap_empty) begin
         out_valid_ff <= 1'b0;
         out_name_ff  <= '0;
         out_len_ff   <= '0;
         out_count_ff <= '0;
         out_last_ff  <= 1'b1;
      end
      if (cmd.cap_entry | cmd.cap_empty) begin
         out_trunc_ff <= trunc_ff;
         out_ovf_ff   <= ovf_ff;
      end
   end

   assign out_name_wide      = OUT_W'(out_name_ff);
   assign rsp_strobe         = out_strobe_ff;
   assign rsp_entry_valid    = out_valid_ff;
   assign rsp_name_part0     = out_name_wide[63:0];
   assign rsp_name_part1     = out_name_wide[127:64];
   assign rsp_name_part2     = out_name_wide[151:128];
   assign rsp_name_length    = LEN_W'(out_len_ff);
   assign rsp_occurrences    = OCC_W'(out_count_ff);
   assign rsp_name_truncated = out_trunc_ff;
   assign rsp_table_overflow = out_ovf_ff;
   assign rsp_last           = out_last_ff;

   `ASSERT_SYNC(a_idx_in_range, clock, reset, idx_ff <= used_ff, "table index beyond fill")
   `ASSERT_SYNC(a_used_in_range, clock, reset, used_ff <= USED_MAX, "table fill beyond depth")
   `ASSERT_SYNC(a_fill_in_range, clock, reset, fill_ff <= FILL_MAX, "name fill beyond buffer")
   `ASSERT_SYNC(a_empty_is_last, clock, reset, !(out_strobe_ff && !out_valid_ff) || out_last_ff, "empty beat without last")
   `ASSERT_NEXT(a_last_clears, clock, reset, out_strobe_ff && out_last_ff, used_ff == '0, "table not cleared after dump")

endmodule

// ===== sv/markup_tag_occurrence_counter.sv =====
// Top level of the markup tag occurrence counter.
// Input: one beat per stream byte on req_data_byte, taken when start is high and
//    busy is low. A beat with req_end_of_stream high ends the stream instead.
// A byte that closes a tag name starts a sequential search of the name table RAM,
//    oldest entry first, with a read state and a compare state per entry; busy stays
//    high until a hit, or on a miss until the name is appended or overflow is flagged.
// End of stream dumps the table newest first: each entry is read, then captured into
//    the result registers, and a clear state ends the dump. An empty table gives one
//    beat with rsp_entry_valid low.
// rsp_last marks the final beat; the block then returns to its reset state.
// Result beats are held for exactly one cycle under rsp_strobe; the receiver
//    cannot stall them.
// Reset is synchronous and clears parser, fill count and flags; the table RAM
//    needs no clearing, since only filled rows are ever read.
module markup_tag_occurrence_counter #(
   parameter int TABLE_ENTRIES = mtoc_pkg::TABLE_ENTRIES_DEF,
   parameter int NAME_BYTES    = mtoc_pkg::NAME_BYTES_DEF,
   parameter int COUNT_BITS    = mtoc_pkg::COUNT_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_strobe,
   output logic        rsp_entry_valid,
   output logic [63:0] rsp_name_part0,
   output logic [63:0] rsp_name_part1,
   output logic [23:0] rsp_name_part2,
   output logic [4:0]  rsp_name_length,
   output logic [15:0] rsp_occurrences,
   output logic        rsp_name_truncated,
   output logic        rsp_table_overflow,
   output logic        rsp_last
);

   mtoc_pkg::dp_cmd_type    cmd;
   mtoc_pkg::dp_status_type status;

   mtoc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .end_of_stream (req_end_of_stream),
      .status        (status),
      .cmd           (cmd),
      .busy          (busy)
   );

   mtoc_dp #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .NAME_BYTES    (NAME_BYTES),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .data_byte          (req_data_byte),
      .rsp_strobe         (rsp_strobe),
      .rsp_entry_valid    (rsp_entry_valid),
      .rsp_name_part0     (rsp_name_part0),
      .rsp_name_part1     (rsp_name_part1),
      .rsp_name_part2     (rsp_name_part2),
      .rsp_name_length    (rsp_name_length),
      .rsp_occurrences    (rsp_occurrences),
      .rsp_name_truncated (rsp_name_truncated),
      .rsp_table_overflow (rsp_table_overflow),
      .rsp_last           (rsp_last)
   );

endmodule

// ===== tb/tag_count_checker.sv =====
// Scoreboard for the tag counter: tracks the byte stream, predicts dump beats and compares them.
module tag_count_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   input  logic        rsp_strobe,
   input  logic        rsp_entry_valid,
   input  logic [63:0] rsp_name_part0,
   input  logic [63:0] rsp_name_part1,
   input  logic [23:0] rsp_name_part2,
   input  logic [4:0]  rsp_name_length,
   input  logic [15:0] rsp_occurrences,
   input  logic        rsp_name_truncated,
   input  logic        rsp_table_overflow,
   input  logic        rsp_last,
   output int          failures,
   output int          pending
);

   localparam int SLOTS    = mtoc_pkg::TABLE_ENTRIES_DEF;
   localparam int NAME_LEN = mtoc_pkg::NAME_BYTES_DEF;
   localparam int OCC_W    = mtoc_pkg::OCC_BITS;
   localparam int LEN_W    = mtoc_pkg::LENGTH_BITS;
   localparam int NAME_W   = mtoc_pkg::NAME_OUT_BITS;
   localparam logic [OCC_W-1:0] COUNT_CEIL = '1;

   typedef enum logic [1:0] {SEEK_LT, AFTER_LT, IN_CLOSE, IN_OPEN} scan_state_type;

   typedef struct packed {
      logic             valid;
      logic [63:0]      part0;
      logic [63:0]      part1;
      logic [23:0]      part2;
      logic [LEN_W-1:0] length;
      logic [OCC_W-1:0] count;
      logic             trunc;
      logic             ovf;
      logic             last;
   } dump_beat_type;

   scan_state_type    scan;
   logic [NAME_W-1:0] cur_name;
   int                cur_len;
   logic [NAME_W-1:0] slot_name [SLOTS];
   int                slot_len [SLOTS];
   logic [OCC_W-1:0]  slot_count [SLOTS];
   int                slots_used;
   logic              seen_trunc;
   logic              seen_ovf;
   dump_beat_type     beats_due [$];

   task automatic clear_tally();
      scan       = SEEK_LT;
      cur_name   = '0;
      cur_len    = 0;
      slots_used = 0;
      seen_trunc = 1'b0;
      seen_ovf   = 1'b0;
   endtask

   task automatic take_name_byte(input logic [7:0] b);
      if (cur_len < NAME_LEN) begin
         cur_name[cur_len*8 +: 8] = b;
         cur_len++;
      end else begin
         seen_trunc = 1'b1;
      end
   endtask

   // names are zero past their length, so a full-width compare suffices
   task automatic count_name();
      for (int k = 0; k < slots_used; k++) begin
         if (slot_len[k] == cur_len && slot_name[k] == cur_name) begin
            if (slot_count[k] != COUNT_CEIL) slot_count[k]++;
            return;
         end
      end
      if (slots_used < SLOTS) begin
         slot_name[slots_used]  = cur_name;
         slot_len[slots_used]   = cur_len;
         slot_count[slots_used] = OCC_W'(1);
         slots_used++;
      end else begin
         seen_ovf = 1'b1;
      end
   endtask

   task automatic tally_byte(input logic [7:0] b);
      case (scan)
         SEEK_LT: begin
            if (b == mtoc_pkg::CHAR_LT) scan = AFTER_LT;
         end
         AFTER_LT: begin
            cur_name = '0;
            cur_len  = 0;
            if (b == mtoc_pkg::CHAR_SLASH) begin
               scan = IN_CLOSE;
            end else begin
               take_name_byte(b);
               scan = IN_OPEN;
            end
         end
         IN_CLOSE: begin
            if (b == mtoc_pkg::CHAR_GT) begin
               count_name();
               scan = SEEK_LT;
            end else begin
               take_name_byte(b);
            end
         end
         default: begin
            if (b == mtoc_pkg::CHAR_SPACE || b == mtoc_pkg::CHAR_GT) begin
               count_name();
               scan = SEEK_LT;
            end else begin
               take_name_byte(b);
            end
         end
      endcase
   endtask

   // newest entry first; an empty table gives a single invalid beat
   task automatic queue_dump();
      dump_beat_type d;
      if (slots_used == 0) begin
         d       = '0;
         d.trunc = seen_trunc;
         d.ovf   = seen_ovf;
         d.last  = 1'b1;
         beats_due.push_back(d);
      end else begin
         for (int k = slots_used - 1; k >= 0; k--) begin
            d.valid  = 1'b1;
            d.part0  = slot_name[k][63:0];
            d.part1  = slot_name[k][127:64];
            d.part2  = slot_name[k][151:128];
            d.length = LEN_W'(slot_len[k]);
            d.count  = slot_count[k];
            d.trunc  = seen_trunc;
            d.ovf    = seen_ovf;
            d.last   = (k == 0);
            beats_due.push_back(d);
         end
      end
      clear_tally();
   endtask

   task automatic note_failure(input string what, input dump_beat_type want,
                               input dump_beat_type got);
      failures++;
      if (failures <= 10)
         $display("mismatch on %s: expected %h, got %h", what, want, got);
   endtask

   task automatic check_beat(input dump_beat_type got);
      dump_beat_type want;
      if (beats_due.size() == 0) begin
         note_failure("unexpected result beat", '0, got);
         return;
      end
      want = beats_due.pop_front();
      if (got !== want) note_failure("result beat", want, got);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_tally();
         beats_due.delete();
         failures = 0;
      end else begin
         if (rsp_strobe)
            check_beat({rsp_entry_valid, rsp_name_part0, rsp_name_part1, rsp_name_part2,
                        rsp_name_length, rsp_occurrences, rsp_name_truncated,
                        rsp_table_overflow, rsp_last});
         if (start && !busy) begin
            if (req_end_of_stream) queue_dump();
            else tally_byte(req_data_byte);
         end
      end
      pending = beats_due.size();
   end

endmodule

// ===== tb/markup_tag_occurrence_counter_tb.sv =====
// Testbench top for the markup tag occurrence counter: stream stimulus and verdict.
module markup_tag_occurrence_counter_tb;

   localparam int RANDOM_BEATS = 360;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 2 * mtoc_pkg::TABLE_ENTRIES_DEF + 16;
   localparam int POOL_MAX     = 40;
   localparam int POOL_BYTES   = 24;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_data_byte;
   logic        req_end_of_stream;
   logic        rsp_strobe;
   logic        rsp_entry_valid;
   logic [63:0] rsp_name_part0;
   logic [63:0] rsp_name_part1;
   logic [23:0] rsp_name_part2;
   logic [4:0]  rsp_name_length;
   logic [15:0] rsp_occurrences;
   logic        rsp_name_truncated;
   logic        rsp_table_overflow;
   logic        rsp_last;

   int   failures;
   int   pending;
   int   beats_sent;
   int   cycles;
   bit   idling;
   logic [7:0] pool_text [POOL_MAX][POOL_BYTES];
   int   pool_len [POOL_MAX];

   always #5 clock = ~clock;

   markup_tag_occurrence_counter DUT (.*);

   tag_count_checker tally_chk (.*);

   task automatic send_beat(input logic [7:0] b, input logic eos);
      start             <= 1'b1;
      req_data_byte     <= b;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (busy) @(posedge clock);
      beats_sent++;
      if (idling && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic send_noise(input bit allow_lt);
      logic [7:0] b;
      repeat ($urandom_range(1, 3)) begin
         do b = 8'($urandom_range(0, 255)); while (!allow_lt && b == mtoc_pkg::CHAR_LT);
         send_beat(b, 1'b0);
      end
   endtask

   // pool names avoid open-tag terminators and a leading slash
   task automatic make_pool(input int n, input int min_len, input int max_len, input bit long_ok);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         pool_len[i] = $urandom_range(min_len, max_len);
         if (long_ok && $urandom_range(0, 7) == 0) pool_len[i] = $urandom_range(20, POOL_BYTES);
         for (int j = 0; j < POOL_BYTES; j++) begin
            do b = 8'($urandom_range(0, 255));
            while (b == mtoc_pkg::CHAR_SPACE || b == mtoc_pkg::CHAR_GT ||
                   (j == 0 && b == mtoc_pkg::CHAR_SLASH));
            pool_text[i][j] = b;
         end
      end
   endtask

   task automatic send_tag(input int idx);
      send_beat(mtoc_pkg::CHAR_LT, 1'b0);
      if (pool_len[idx] == 0 || $urandom_range(0, 2) == 0) begin
         send_beat(mtoc_pkg::CHAR_SLASH, 1'b0);
         for (int j = 0; j < pool_len[idx]; j++) send_beat(pool_text[idx][j], 1'b0);
         send_beat(mtoc_pkg::CHAR_GT, 1'b0);
      end else begin
         for (int j = 0; j < pool_len[idx]; j++) send_beat(pool_text[idx][j], 1'b0);
         if ($urandom_range(0, 1)) begin
            send_beat(mtoc_pkg::CHAR_SPACE, 1'b0);
            if ($urandom_range(0, 1)) send_noise(1'b0);
         end
         send_beat(mtoc_pkg::CHAR_GT, 1'b0);
      end
   endtask

   // fill_table: enough distinct names to overflow the table, then some repeats
   task automatic random_stream(input bit fill_table);
      int n_names;
      int n_tags;
      int idx;
      idling = $urandom_range(0, 2) != 0;
      if (fill_table || $urandom_range(0, 5) == 0) begin
         fill_table = 1'b1;
         n_names = $urandom_range(35, POOL_MAX);
         n_tags  = n_names + $urandom_range(2, 8);
         make_pool(n_names, 2, 3, 1'b0);
      end else if ($urandom_range(0, 1)) begin
         n_names = $urandom_range(1, 4);
         n_tags  = $urandom_range(0, 10);
         make_pool(n_names, 0, 4, 1'b1);
      end else begin
         n_names = $urandom_range(5, 12);
         n_tags  = $urandom_range(2, 14);
         make_pool(n_names, 0, 19, 1'b1);
      end
      for (int t = 0; t < n_tags; t++) begin
         if ($urandom_range(0, 3) == 0) send_noise($urandom_range(0, 4) == 0);
         idx = (fill_table && t < n_names) ? t : $urandom_range(0, n_names - 1);
         send_tag(idx);
      end
      // broken tag left open at end of stream
      if ($urandom_range(0, 3) == 0) begin
         idx = $urandom_range(0, n_names - 1);
         send_beat(mtoc_pkg::CHAR_LT, 1'b0);
         if ($urandom_range(0, 1)) send_beat(mtoc_pkg::CHAR_SLASH, 1'b0);
         for (int j = 0; j < $urandom_range(0, pool_len[idx]); j++)
            send_beat(pool_text[idx][j], 1'b0);
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin
      int base;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_data_byte     <= '0;
      req_end_of_stream <= 1'b0;
      beats_sent = 0;
      idling     = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_beat(8'h00, 1'b1);
      send_text("</>");
      send_text("<>>");
      send_text("< >");
      send_beat(mtoc_pkg::CHAR_LT, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'hFF, 1'b0);
      send_beat(mtoc_pkg::CHAR_SPACE, 1'b0);
      send_text("</a b>");
      send_beat(8'hFF, 1'b1);
      // overlong name never closed: empty table with the truncation flag set
      send_beat(mtoc_pkg::CHAR_LT, 1'b0);
      repeat (20) send_beat("x", 1'b0);
      send_beat(8'h5A, 1'b1);

      base = beats_sent;
      random_stream(1'b1);
      while (beats_sent < base + RANDOM_BEATS) random_stream(1'b0);

      // closing stretch with back-to-back beats, no idling from here on
      idling = 1'b0;
      send_text("<a>");
      send_text("</a>");
      send_text("<b ");
      send_beat(8'h00, 1'b1);

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb: failure");
      $finish;
   end

endmodule
